[rtl/tss_pkg.sv]
// Package for the tick scheduler and status supervisor.
// Holds widths, constants, register indexes, state and command types.
// Used by tss_ctrl, tss_datapath and tick_scheduler_status_supervisor.
`default_nettype none

package tss_pkg;

    localparam int TICK_W   = 14;
    localparam int VOLT_W   = 10;
    localparam int SPEED_W  = 16;
    localparam int MOTOR_W  = 10;
    localparam int WD_W     = 16;
    localparam int LED_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int STEP_W   = 4;

    localparam logic [TICK_W-1:0] CYCLE_TICKS = 14'd10000;
    localparam logic [TICK_W-1:0] TICKS_100MS = 14'd100;
    localparam logic [TICK_W-1:0] TICKS_200MS = 14'd200;
    localparam logic [4:0]        LED_PAUSE_STEPS = 5'd4;
    localparam logic [WD_W-1:0]   WATCHDOG_LIMIT  = 16'd2;
    localparam logic [WD_W-1:0]   WD_MAX          = 16'hFFFF;
    localparam logic [STEP_W-1:0] DIV_STEPS       = 4'd14;

    localparam logic [MOTOR_W-1:0] MOTOR_INTERVAL_RST  = 10'd100;
    localparam logic [TICK_W-1:0]  STATUS_INTERVAL_RST = 14'd100;
    localparam logic [VOLT_W-1:0]  BATTERY_THRESH_RST  = 10'd682;

    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LOOP     = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PARSER   = 2'd1;
    localparam logic [1:0] STATUS_WATCHDOG = 2'd2;
    localparam logic [1:0] STATUS_BATTERY  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE
    } tss_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } tss_cmd_t;

    typedef struct packed {
        logic div_done;
    } tss_stat_t;

endpackage

`default_nettype wire

[rtl/tss_ctrl.sv]
// Controller state machine for the tick scheduler and status supervisor.
// Sequences word load, remainder steps and state update; owns output valid.
// Depends on tss_pkg.
`default_nettype none

module tss_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  tss_pkg::tss_stat_t  stat,
    output tss_pkg::tss_cmd_t   cmd
);

    tss_pkg::tss_state_t state_reg;
    tss_pkg::tss_state_t state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tss_pkg::ST_DIV;
                end
            end
            tss_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = tss_pkg::ST_UPDATE;
                end
            end
            tss_pkg::ST_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = tss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tss_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            tss_pkg::ST_UPDATE:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tss_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/tss_datapath.sv]
// Datapath for the tick scheduler and status supervisor: configuration,
// tick and supervisor state, two-lane bit-serial remainder unit, result word.
// Depends on tss_pkg.
`default_nettype none

module tss_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  tss_pkg::tss_cmd_t                     cmd,
    output tss_pkg::tss_stat_t                    stat,
    input  wire logic                             cfg_we,
    input  wire logic [tss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [tss_pkg::VOLT_W-1:0]       voltage_sample,
    input  wire logic signed [tss_pkg::SPEED_W-1:0] left_speed_setpoint,
    input  wire logic signed [tss_pkg::SPEED_W-1:0] right_speed_setpoint,
    input  wire logic                             control_packet_seen,
    input  wire logic                             parser_error_seen,
    output logic                                  pid_update_strobe,
    output logic                                  open_loop_update_strobe,
    output logic                                  status_send_strobe,
    output logic [1:0]                            status_code,
    output logic                                  led_lit,
    output logic                                  battery_low,
    output logic [tss_pkg::VOLT_W-1:0]            reported_voltage
);

    localparam int LANES = 2;

    logic [tss_pkg::MOTOR_W-1:0] motor_interval_reg;
    logic [tss_pkg::TICK_W-1:0]  status_interval_reg;
    logic                        watchdog_enable_reg;
    logic [tss_pkg::VOLT_W-1:0]  battery_threshold_reg;
    logic                        closed_loop_reg;

    logic [tss_pkg::TICK_W-1:0]  tick_count_reg;
    logic [tss_pkg::TICK_W-1:0]  tick_inc;
    logic [tss_pkg::TICK_W-1:0]  phase100_reg;
    logic [tss_pkg::TICK_W-1:0]  phase200_reg;
    logic [tss_pkg::TICK_W-1:0]  phase100_inc;
    logic [tss_pkg::TICK_W-1:0]  phase200_inc;
    logic [tss_pkg::WD_W-1:0]    watchdog_count_reg;
    logic                        error_pending_reg;
    logic [1:0]                  status_reg;
    logic                        battery_flag_reg;
    logic [tss_pkg::VOLT_W-1:0]  voltage_latch_reg;
    logic                        led_phase_reg;
    logic [tss_pkg::LED_W-1:0]   led_step_reg;

    logic [tss_pkg::VOLT_W-1:0]  voltage_in_reg;
    logic                        speeds_zero_reg;

    logic [tss_pkg::TICK_W-1:0]  div_shift_reg;
    logic [tss_pkg::STEP_W-1:0]  div_cnt_reg;
    logic [tss_pkg::TICK_W-1:0]  rem_reg  [LANES];
    logic [tss_pkg::TICK_W-1:0]  rem_next [LANES];
    logic [tss_pkg::TICK_W:0]    divisor  [LANES];

    logic                        motor_hit;
    logic                        status_hit;
    logic                        hit_100;
    logic                        hit_200;
    logic [tss_pkg::WD_W-1:0]    wd_next;
    logic [1:0]                  status_next;
    logic                        error_next;
    logic [tss_pkg::VOLT_W-1:0]  volt_latch_next;
    logic                        led_phase_next;
    logic [tss_pkg::LED_W-1:0]   led_step_next;
    logic [tss_pkg::LED_W-1:0]   led_step_inc;
    logic [4:0]                  flashes;
    logic                        battery_next;

    assign tick_inc = (tick_count_reg + 14'd1 >= tss_pkg::CYCLE_TICKS)
                      ? '0 : tick_count_reg + 14'd1;

    // The 100 ms and 200 ms phases follow the tick count and restart with it.
    assign phase100_inc = ((tick_inc == '0) || (phase100_reg == tss_pkg::TICKS_100MS - 14'd1))
                          ? '0 : phase100_reg + 14'd1;
    assign phase200_inc = ((tick_inc == '0) || (phase200_reg == tss_pkg::TICKS_200MS - 14'd1))
                          ? '0 : phase200_reg + 14'd1;

    assign divisor[0] = {5'd0, motor_interval_reg};
    assign divisor[1] = {1'b0, status_interval_reg};

    always_comb
    begin
        logic [tss_pkg::TICK_W:0] trial;
        for (int i = 0; i < LANES; i++)
        begin
            trial = {rem_reg[i], div_shift_reg[tss_pkg::TICK_W-1]};
            if (trial >= divisor[i])
            begin
                trial = trial - divisor[i];
            end
            rem_next[i] = trial[tss_pkg::TICK_W-1:0];
        end
    end

    assign stat.div_done = (div_cnt_reg == tss_pkg::DIV_STEPS - 4'd1);

    assign motor_hit  = (motor_interval_reg != '0) && (rem_reg[0] == '0);
    assign status_hit = (status_interval_reg != '0) && (rem_reg[1] == '0);
    assign hit_100    = (phase100_reg == '0);
    assign hit_200    = (phase200_reg == '0);

    always_comb
    begin
        wd_next         = watchdog_count_reg;
        status_next     = status_reg;
        error_next      = error_pending_reg;
        volt_latch_next = voltage_latch_reg;
        if (hit_100)
        begin
            if (watchdog_enable_reg)
            begin
                if (watchdog_count_reg < tss_pkg::WD_MAX)
                begin
                    wd_next = watchdog_count_reg + 16'd1;
                end
            end
            else
            begin
                wd_next = '0;
            end
            volt_latch_next = voltage_in_reg;
            if (battery_flag_reg)
            begin
                status_next = tss_pkg::STATUS_BATTERY;
            end
            else if (wd_next > tss_pkg::WATCHDOG_LIMIT)
            begin
                status_next = tss_pkg::STATUS_WATCHDOG;
            end
            else if (error_pending_reg)
            begin
                status_next = tss_pkg::STATUS_PARSER;
                error_next  = 1'b0;
            end
            else
            begin
                status_next = tss_pkg::STATUS_OK;
            end
        end
    end

    assign flashes      = {3'd0, status_next} + 5'd1;
    assign led_step_inc = led_step_reg + 4'd1;

    always_comb
    begin
        led_phase_next = led_phase_reg;
        led_step_next  = led_step_reg;
        battery_next   = battery_flag_reg;
        if (hit_200)
        begin
            if (led_phase_reg)
            begin
                led_phase_next = 1'b0;
            end
            else
            begin
                led_step_next = led_step_inc;
                if ({1'b0, led_step_inc} <= flashes)
                begin
                    led_phase_next = 1'b1;
                end
                else if ({1'b0, led_step_inc} > flashes + tss_pkg::LED_PAUSE_STEPS)
                begin
                    led_step_next = '0;
                end
            end
            if (speeds_zero_reg)
            begin
                battery_next = (volt_latch_next < battery_threshold_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_interval_reg    <= tss_pkg::MOTOR_INTERVAL_RST;
            status_interval_reg   <= tss_pkg::STATUS_INTERVAL_RST;
            watchdog_enable_reg   <= 1'b1;
            battery_threshold_reg <= tss_pkg::BATTERY_THRESH_RST;
            closed_loop_reg       <= 1'b0;
            tick_count_reg        <= '0;
            phase100_reg          <= '0;
            phase200_reg          <= '0;
            watchdog_count_reg    <= tss_pkg::WATCHDOG_LIMIT + 16'd1;
            error_pending_reg     <= 1'b0;
            status_reg            <= tss_pkg::STATUS_WATCHDOG;
            battery_flag_reg      <= 1'b0;
            voltage_latch_reg     <= '0;
            led_phase_reg         <= 1'b0;
            led_step_reg          <= '0;
            div_cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tss_pkg::REG_MOTOR_INTERVAL:
                        motor_interval_reg <= cfg_wdata[tss_pkg::MOTOR_W-1:0];
                    tss_pkg::REG_STATUS_INTERVAL:
                        status_interval_reg <= cfg_wdata;
                    tss_pkg::REG_WATCHDOG_ENABLE:
                        watchdog_enable_reg <= cfg_wdata[0];
                    tss_pkg::REG_BATTERY_THRESH:
                        battery_threshold_reg <= cfg_wdata[tss_pkg::VOLT_W-1:0];
                    tss_pkg::REG_CLOSED_LOOP:
                        closed_loop_reg <= cfg_wdata[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load)
            begin
                tick_count_reg <= tick_inc;
                phase100_reg   <= phase100_inc;
                phase200_reg   <= phase200_inc;
                div_cnt_reg    <= '0;
                if (control_packet_seen)
                begin
                    watchdog_count_reg <= '0;
                end
                if (parser_error_seen)
                begin
                    error_pending_reg <= 1'b1;
                end
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            else if (cmd.commit)
            begin
                watchdog_count_reg <= wd_next;
                error_pending_reg  <= error_next;
                status_reg         <= status_next;
                battery_flag_reg   <= battery_next;
                voltage_latch_reg  <= volt_latch_next;
                led_phase_reg      <= led_phase_next;
                led_step_reg       <= led_step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            voltage_in_reg  <= voltage_sample;
            speeds_zero_reg <= (left_speed_setpoint == '0) && (right_speed_setpoint == '0);
            div_shift_reg   <= tick_inc;
            for (int i = 0; i < LANES; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            div_shift_reg <= {div_shift_reg[tss_pkg::TICK_W-2:0], 1'b0};
            for (int i = 0; i < LANES; i++)
            begin
                rem_reg[i] <= rem_next[i];
            end
        end
        if (cmd.commit)
        begin
            pid_update_strobe       <= motor_hit && closed_loop_reg;
            open_loop_update_strobe <= motor_hit && !closed_loop_reg;
            status_send_strobe      <= status_hit;
            status_code             <= status_next;
            led_lit                 <= led_phase_next;
            battery_low             <= battery_next;
            reported_voltage        <= volt_latch_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tick_scheduler_status_supervisor.sv]
// Top level of the tick scheduler and status supervisor.
// Joins the controller tss_ctrl and the datapath tss_datapath; uses tss_pkg.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    voltage_sample, speed setpoints, packet and error flags
//   output   out_valid / out_ready  strobes, status_code, led_lit, battery_low, voltage
//   config   cfg_we                 cfg_index, cfg_wdata
//
// Each input word is accepted, then takes fourteen steps of the bit-serial
// remainder unit that divides the new tick count, and then the update.
// The update waits while the output register still holds an untaken word.
// After reset the block is idle and ready, with the registers at their defaults.
`default_nettype none

module tick_scheduler_status_supervisor (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [tss_pkg::VOLT_W-1:0]         voltage_sample,
    input  wire logic signed [tss_pkg::SPEED_W-1:0] left_speed_setpoint,
    input  wire logic signed [tss_pkg::SPEED_W-1:0] right_speed_setpoint,
    input  wire logic                               control_packet_seen,
    input  wire logic                               parser_error_seen,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    pid_update_strobe,
    output logic                                    open_loop_update_strobe,
    output logic                                    status_send_strobe,
    output logic [1:0]                              status_code,
    output logic                                    led_lit,
    output logic                                    battery_low,
    output logic [tss_pkg::VOLT_W-1:0]              reported_voltage,
    input  wire logic                               cfg_we,
    input  wire logic [tss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    tss_pkg::tss_cmd_t  cmd;
    tss_pkg::tss_stat_t stat;

    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tss_datapath u_datapath (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .stat                    (stat),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_wdata               (cfg_wdata),
        .voltage_sample          (voltage_sample),
        .left_speed_setpoint     (left_speed_setpoint),
        .right_speed_setpoint    (right_speed_setpoint),
        .control_packet_seen     (control_packet_seen),
        .parser_error_seen       (parser_error_seen),
        .pid_update_strobe       (pid_update_strobe),
        .open_loop_update_strobe (open_loop_update_strobe),
        .status_send_strobe      (status_send_strobe),
        .status_code             (status_code),
        .led_lit                 (led_lit),
        .battery_low             (battery_low),
        .reported_voltage        (reported_voltage)
    );

endmodule

`default_nettype wire

[dv/tb_tick_scheduler_status_supervisor.sv]
// Self-checking testbench for tick_scheduler_status_supervisor.
// A directed table and random phases under several register settings are checked
// word by word against a tick predictor; depends on rtl/tss_pkg.sv and the RTL top.
module tb_tick_scheduler_status_supervisor;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [tss_pkg::VOLT_W-1:0]     volt_t;
    typedef logic [tss_pkg::SPEED_W-1:0]    speed_t;
    typedef logic [tss_pkg::TICK_W-1:0]     tick_t;
    typedef logic [tss_pkg::MOTOR_W-1:0]    motor_t;
    typedef logic [tss_pkg::CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        volt_t  voltage;
        speed_t left;
        speed_t right;
        logic   packet;
        logic   parser_err;
    } tick_word_t;

    typedef struct packed {
        logic       pid;
        logic       open_loop;
        logic       send;
        logic [1:0] status;
        logic       led;
        logic       batt;
        volt_t      volt;
    } tick_report_t;

    typedef struct packed {
        tick_word_t   word;
        logic         typed;
        tick_report_t report;
    } directed_row_t;

    localparam int DIRECTED_WORDS = 20;
    localparam int TOTAL_WORDS = DIRECTED_WORDS + 100 + 80 + 80 + 60 + 3 * 20;
    localparam int CYCLE_LIMIT = TOTAL_WORDS * 180 + 10000;

    localparam tick_report_t IDLE_REPORT = '{1'b0, 1'b0, 1'b0, tss_pkg::STATUS_WATCHDOG,
                                             1'b0, 1'b0, 10'd0};

    directed_row_t directed_rows [DIRECTED_WORDS] = '{
        '{'{10'd0,    16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'd1023, 16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'd1023, 16'h7FFF, 16'h8000, 1'b1, 1'b1}, 1'b1, IDLE_REPORT},
        '{'{10'd0,    16'h8000, 16'h7FFF, 1'b0, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'h2AA,  16'hFFFF, 16'hFFFF, 1'b1, 1'b0}, 1'b0, IDLE_REPORT},
        '{'{10'h155,  16'h5555, 16'hAAAA, 1'b0, 1'b1}, 1'b0, IDLE_REPORT},
        '{'{10'd0,    16'h0001, 16'h0000, 1'b0, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'd0,    16'h0000, 16'h0001, 1'b1, 1'b1}, 1'b0, IDLE_REPORT},
        '{'{10'h3FF,  16'hAAAA, 16'h5555, 1'b0, 1'b0}, 1'b0, IDLE_REPORT},
        '{'{10'h200,  16'h0000, 16'h0000, 1'b1, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'h1FF,  16'h0000, 16'h0000, 1'b0, 1'b1}, 1'b0, IDLE_REPORT},
        '{'{10'h2AA,  16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'h2A9,  16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b0, IDLE_REPORT},
        '{'{10'h2AB,  16'h8000, 16'h0000, 1'b1, 1'b1}, 1'b0, IDLE_REPORT},
        '{'{10'd0,    16'h0000, 16'h8000, 1'b0, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'h3FF,  16'h7FFF, 16'h7FFF, 1'b1, 1'b0}, 1'b0, IDLE_REPORT},
        '{'{10'd0,    16'hFFFF, 16'h0000, 1'b0, 1'b1}, 1'b1, IDLE_REPORT},
        '{'{10'h155,  16'h0000, 16'hFFFF, 1'b1, 1'b1}, 1'b0, IDLE_REPORT},
        '{'{10'd0,    16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b1, IDLE_REPORT},
        '{'{10'h3FF,  16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b1, IDLE_REPORT}
    };

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    volt_t                                  voltage_sample = '0;
    logic signed [tss_pkg::SPEED_W-1:0]     left_speed_setpoint = '0;
    logic signed [tss_pkg::SPEED_W-1:0]     right_speed_setpoint = '0;
    logic                                   control_packet_seen = 1'b0;
    logic                                   parser_error_seen = 1'b0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic                                   pid_update_strobe;
    logic                                   open_loop_update_strobe;
    logic                                   status_send_strobe;
    logic [1:0]                             status_code;
    logic                                   led_lit;
    logic                                   battery_low;
    volt_t                                  reported_voltage;
    logic                                   cfg_we = 1'b0;
    logic [tss_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
    cfg_data_t                              cfg_wdata = '0;

    // Predictor state and its copy of the registers.
    tick_t                         tick_q;
    logic [tss_pkg::WD_W-1:0]      wd_q;
    logic                          err_q;
    logic [1:0]                    status_q;
    logic                          batt_q;
    volt_t                         volt_q;
    logic                          led_on_q;
    logic [tss_pkg::LED_W-1:0]     led_pos_q;
    motor_t                        motor_iv;
    tick_t                         status_iv;
    logic                          wd_en;
    volt_t                         batt_thr;
    logic                          closed_loop;

    tick_report_t due_reports [$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    int           packet_pct = 5;
    int           error_pct = 2;
    int           still_pct = 50;
    logic [31:0]  ready_pattern = 32'hFFFF_FFFF;

    tick_scheduler_status_supervisor uut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .voltage_sample          (voltage_sample),
        .left_speed_setpoint     (left_speed_setpoint),
        .right_speed_setpoint    (right_speed_setpoint),
        .control_packet_seen     (control_packet_seen),
        .parser_error_seen       (parser_error_seen),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .pid_update_strobe       (pid_update_strobe),
        .open_loop_update_strobe (open_loop_update_strobe),
        .status_send_strobe      (status_send_strobe),
        .status_code             (status_code),
        .led_lit                 (led_lit),
        .battery_low             (battery_low),
        .reported_voltage        (reported_voltage),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_wdata               (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic reset_supervisor_model();
        motor_iv    = tss_pkg::MOTOR_INTERVAL_RST;
        status_iv   = tss_pkg::STATUS_INTERVAL_RST;
        wd_en       = 1'b1;
        batt_thr    = tss_pkg::BATTERY_THRESH_RST;
        closed_loop = 1'b0;
        tick_q      = '0;
        wd_q        = tss_pkg::WATCHDOG_LIMIT + 16'd1;
        err_q       = 1'b0;
        status_q    = tss_pkg::STATUS_WATCHDOG;
        batt_q      = 1'b0;
        volt_q      = '0;
        led_on_q    = 1'b0;
        led_pos_q   = '0;
    endtask

    function automatic tick_report_t advance_tick(input tick_word_t w);
        tick_report_t r;
        logic         motor_hit;
        logic         send_hit;
        int           flashes;
        if (w.packet)
            wd_q = '0;
        if (w.parser_err)
            err_q = 1'b1;
        if (int'(tick_q) + 1 >= int'(tss_pkg::CYCLE_TICKS))
            tick_q = '0;
        else
            tick_q = tick_q + 14'd1;
        motor_hit = (motor_iv != 0) && (int'(tick_q) % int'(motor_iv) == 0);
        send_hit  = (status_iv != 0) && (int'(tick_q) % int'(status_iv) == 0);
        if (int'(tick_q) % int'(tss_pkg::TICKS_100MS) == 0)
        begin
            if (wd_en)
            begin
                if (wd_q != tss_pkg::WD_MAX)
                    wd_q = wd_q + 16'd1;
            end
            else
                wd_q = '0;
            volt_q = w.voltage;
            if (batt_q)
                status_q = tss_pkg::STATUS_BATTERY;
            else if (wd_q > tss_pkg::WATCHDOG_LIMIT)
                status_q = tss_pkg::STATUS_WATCHDOG;
            else if (err_q)
            begin
                status_q = tss_pkg::STATUS_PARSER;
                err_q = 1'b0;
            end
            else
                status_q = tss_pkg::STATUS_OK;
        end
        if (int'(tick_q) % int'(tss_pkg::TICKS_200MS) == 0)
        begin
            flashes = int'(status_q) + 1;
            if (led_on_q)
                led_on_q = 1'b0;
            else
            begin
                led_pos_q = led_pos_q + 4'd1;
                if (int'(led_pos_q) <= flashes)
                    led_on_q = 1'b1;
                else if (int'(led_pos_q) > flashes + int'(tss_pkg::LED_PAUSE_STEPS))
                    led_pos_q = '0;
            end
            if (w.left == 0 && w.right == 0)
                batt_q = (volt_q < batt_thr);
        end
        r.pid       = motor_hit && closed_loop;
        r.open_loop = motor_hit && !closed_loop;
        r.send      = send_hit;
        r.status    = status_q;
        r.led       = led_on_q;
        r.batt      = batt_q;
        r.volt      = volt_q;
        return r;
    endfunction

    function automatic tick_word_t random_word();
        tick_word_t w;
        w.voltage = volt_t'($urandom);
        if ($urandom_range(0, 99) < still_pct)
        begin
            w.left  = '0;
            w.right = '0;
        end
        else
        begin
            w.left  = ($urandom_range(0, 2) == 0) ? '0 : speed_t'($urandom);
            w.right = ($urandom_range(0, 2) == 0) ? '0 : speed_t'($urandom);
        end
        w.packet     = ($urandom_range(0, 99) < packet_pct);
        w.parser_err = ($urandom_range(0, 99) < error_pct);
        return w;
    endfunction

    task automatic send_word(input tick_word_t w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid             <= 1'b1;
        voltage_sample       <= w.voltage;
        left_speed_setpoint  <= w.left;
        right_speed_setpoint <= w.right;
        control_packet_seen  <= w.packet;
        parser_error_seen    <= w.parser_err;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        tick_word_t w;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: packet_pct = 0;
                    1: packet_pct = 1;
                    2: packet_pct = 3;
                    default: packet_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: error_pct = 0;
                    1: error_pct = 1;
                    default: error_pct = 10;
                endcase
                still_pct = ($urandom_range(0, 1) == 1) ? 95 : 10;
            end
            w = random_word();
            send_word(w);
            due_reports.push_back(advance_tick(w));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [tss_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= cfg_data_t'(value);
        @(posedge clk);
        case (idx)
            tss_pkg::REG_MOTOR_INTERVAL:  motor_iv    = motor_t'(value);
            tss_pkg::REG_STATUS_INTERVAL: status_iv   = tick_t'(value);
            tss_pkg::REG_WATCHDOG_ENABLE: wd_en       = value[0];
            tss_pkg::REG_BATTERY_THRESH:  batt_thr    = volt_t'(value);
            tss_pkg::REG_CLOSED_LOOP:     closed_loop = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int motor, input int status, input int wd,
                             input int thr, input int closed);
        drain();
        write_reg(tss_pkg::REG_MOTOR_INTERVAL, motor);
        write_reg(tss_pkg::REG_STATUS_INTERVAL, status);
        write_reg(tss_pkg::REG_WATCHDOG_ENABLE, wd);
        write_reg(tss_pkg::REG_BATTERY_THRESH, thr);
        write_reg(tss_pkg::REG_CLOSED_LOOP, closed);
        cfg_we <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        tick_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_reports.size() == 0)
            begin
                fail_count++;
                $error("output word with no word expected");
            end
            else
            begin
                want = due_reports.pop_front();
                check_field("pid_update_strobe", 16'(want.pid), 16'(pid_update_strobe));
                check_field("open_loop_update_strobe", 16'(want.open_loop),
                            16'(open_loop_update_strobe));
                check_field("status_send_strobe", 16'(want.send), 16'(status_send_strobe));
                check_field("status_code", 16'(want.status), 16'(status_code));
                check_field("led_lit", 16'(want.led), 16'(led_lit));
                check_field("battery_low", 16'(want.batt), 16'(battery_low));
                check_field("reported_voltage", 16'(want.volt), 16'(reported_voltage));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[9:0] == 10'd0)
        begin
            case ($urandom_range(0, 2))
                0: ready_pattern <= 32'hFFFF_FFFF;
                1: ready_pattern <= $urandom | 32'd1;
                default: ready_pattern <= ($urandom & $urandom & $urandom) | 32'd1;
            endcase
        end
        out_ready <= ready_pattern[cycle_count[4:0]];
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_tick_scheduler_status_supervisor: FAIL");
            $finish;
        end
    end

    initial
    begin
        reset_supervisor_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_WORDS; i++)
        begin
            send_word(directed_rows[i].word);
            if (directed_rows[i].typed)
            begin
                void'(advance_tick(directed_rows[i].word));
                due_reports.push_back(directed_rows[i].report);
            end
            else
                due_reports.push_back(advance_tick(directed_rows[i].word));
        end

        run_random(100);
        configure(1, 20, 1, 1023, 1);
        run_random(80);
        configure(0, 0, 0, 0, 0);
        run_random(80);
        configure(1000, 10000, 1, 682, 1);
        run_random(60);
        for (int p = 0; p < 3; p++)
        begin
            configure(($urandom_range(0, 1) == 1) ? $urandom_range(1, 50)
                                                  : $urandom_range(1, 1000),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(20, 10000)
                                                  : $urandom_range(20, 300),
                      $urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1));
            run_random(20);
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && due_reports.size() == 0)
            $display("tb_tick_scheduler_status_supervisor: PASS");
        else
            $display("tb_tick_scheduler_status_supervisor: FAIL");
        $finish;
    end

endmodule
